@@ rtl/core/alm_pkg.sv @@
// Shared types and constants for the alarm table matcher.
package alm_pkg;

   localparam int SLOTS = 8;
   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W = $clog2(SLOTS + 1);
   localparam int SECS_PER_MIN = 60;
   localparam logic [7:0] MAX_RING_RESET = 8'd5;

   typedef enum logic [1:0] {
      ACT_TICK  = 2'd0,
      ACT_STOP  = 2'd1,
      ACT_WRITE = 2'd2,
      ACT_RSVD  = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      MODE_ONCE    = 2'd0,
      MODE_DAILY   = 2'd1,
      MODE_WEEKDAY = 2'd2,
      MODE_NEVER   = 2'd3
   } mode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_WALK,
      ST_LIMIT,
      ST_STOP,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [7:0] melody;
      logic [5:0] minute;
      logic [4:0] hour;
      logic       done;
      logic       active;
      logic       enable;
      logic [1:0] mode;
      logic [6:0] day_mask;
   } slot_type;

endpackage

@@ rtl/core/alarm_table_matcher.sv @@
// Alarm table matcher: slot table in a one-port-read memory, walked once per tick and per ring stop.
// Tick: strobe after the slot walk and limit check, plus a stop walk if the time limit ends the ring.
// Stop while ringing: one stop walk; write, silent stop, unused code: no walk, straight to ST_DONE.
// busy is high until the result beat shows; the next item may start in that beat's cycle.
// The slot walk (one memory read and write-back per cycle) sets the tick latency.
// Synchronous reset clears control, the ring state and the slot valid bits at once.
module alarm_table_matcher
   import alm_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_action,
   input  logic [4:0]  req_hour,
   input  logic [5:0]  req_minute,
   input  logic [2:0]  req_weekday,
   input  logic [31:0] req_now_seconds,
   input  logic [2:0]  req_slot_index,
   input  logic        req_slot_enable,
   input  logic [1:0]  req_recurrence,
   input  logic [6:0]  req_day_mask,
   input  logic [7:0]  req_melody,
   output logic        rsp_valid,
   output logic        rsp_ring_started,
   output logic [2:0]  rsp_ring_slot,
   output logic [7:0]  rsp_ring_melody,
   output logic        rsp_ring_stopped,
   output logic        rsp_ringing,
   output logic        rsp_save_needed,
   input  logic        csr_we,
   input  logic [7:0]  csr_wdata
);

   slot_type              slot_mem [SLOTS];
   logic [SLOTS-1:0]      valid_ff;
   slot_type              rd_data_ff;
   logic                  rd_ok_ff;
   logic [SLOT_W-1:0]     rd_addr;
   logic                  wr_en;
   logic [SLOT_W-1:0]     wr_addr;
   slot_type              wr_data;

   state_type             state_ff, state_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic                  pend_ff, pend_in;
   logic [SLOT_W-1:0]     proc_ff, proc_in;

   logic [4:0]            hour_ff;
   logic [5:0]            minute_ff;
   logic [2:0]            weekday_ff;
   logic [31:0]           now_ff;

   logic [7:0]            max_ring_ff;
   logic                  ring_active_ff, ring_active_in;
   logic [31:0]           ring_start_ff, ring_start_in;
   logic [2:0]            ring_slot_ff, ring_slot_in;

   logic                  started_ff, started_in;
   logic                  stopped_ff, stopped_in;
   logic                  save_ff, save_in;
   logic [7:0]            melody_ff, melody_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  rsp_started_ff, rsp_stopped_ff, rsp_ringing_ff, rsp_save_ff;
   logic [2:0]            rsp_slot_ff;
   logic [7:0]            rsp_melody_ff;

   slot_type              cur;
   slot_type              tick_s;
   slot_type              stop_s;
   logic                  match;
   logic                  fire;
   logic                  tick_save;
   logic [32:0]           limit;
   logic                  over_limit;
   logic                  accept;
   logic                  last_proc;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy = (state_ff != ST_IDLE);
   assign cur = rd_ok_ff ? rd_data_ff : '0;
   assign last_proc = (cnt_ff == CNT_W'(SLOTS));

   // Tick update of the slot coming out of the memory.
   always_comb begin
      tick_s = cur;
      tick_save = 1'b0;
      fire = 1'b0;
      match = (cur.hour == hour_ff) && (cur.minute == minute_ff);
      if (cur.enable) begin
         if (match) begin
            if (!cur.active) begin
               case (mode_type'(cur.mode))
                  MODE_ONCE, MODE_DAILY: fire = 1'b1;
                  MODE_WEEKDAY: fire = (weekday_ff != 3'd7) && cur.day_mask[weekday_ff];
                  default: fire = 1'b0;
               endcase
               if (fire) begin
                  tick_s.active = 1'b1;
               end
            end
         end else if (cur.done) begin
            tick_s.active = 1'b0;
            tick_s.done = 1'b0;
            if (mode_type'(cur.mode) == MODE_ONCE) begin
               tick_s.enable = 1'b0;
               tick_save = 1'b1;
            end
         end
      end
   end

   always_comb begin
      stop_s = cur;
      if (cur.active) begin
         stop_s.done = 1'b1;
      end
   end

   assign limit = {1'b0, ring_start_ff} +
                  33'(14'(max_ring_ff) * 14'(SECS_PER_MIN));
   assign over_limit = limit < {1'b0, now_ff};

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      pend_in = pend_ff;
      proc_in = proc_ff;
      ring_active_in = ring_active_ff;
      ring_start_in = ring_start_ff;
      ring_slot_in = ring_slot_ff;
      started_in = started_ff;
      stopped_in = stopped_ff;
      save_in = save_ff;
      melody_in = melody_ff;
      rsp_valid_in = 1'b0;
      rd_addr = '0;
      wr_en = 1'b0;
      wr_addr = proc_ff;
      wr_data = tick_s;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               started_in = 1'b0;
               stopped_in = 1'b0;
               save_in = 1'b0;
               melody_in = '0;
               cnt_in = CNT_W'(1);
               pend_in = 1'b1;
               proc_in = '0;
               case (action_type'(req_action))
                  ACT_TICK: state_in = ST_WALK;
                  ACT_STOP: begin
                     if (ring_active_ff) begin
                        ring_active_in = 1'b0;
                        ring_start_in = '0;
                        stopped_in = 1'b1;
                        state_in = ST_STOP;
                     end else begin
                        state_in = ST_DONE;
                     end
                  end
                  ACT_WRITE: begin
                     wr_en = (32'(req_slot_index) < SLOTS);
                     wr_addr = SLOT_W'(req_slot_index);
                     wr_data = '{melody: req_melody, minute: req_minute, hour: req_hour,
                                 done: 1'b0, active: 1'b0, enable: req_slot_enable,
                                 mode: req_recurrence, day_mask: req_day_mask};
                     state_in = ST_DONE;
                  end
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_WALK: begin
            // Read the next slot while writing back the one just processed.
            rd_addr = cnt_ff[SLOT_W-1:0];
            wr_en = pend_ff;
            wr_data = tick_s;
            if (fire && !ring_active_ff) begin
               ring_active_in = 1'b1;
               ring_slot_in = 3'(proc_ff);
               ring_start_in = now_ff;
               started_in = 1'b1;
               melody_in = cur.melody;
            end
            if (tick_save) begin
               save_in = 1'b1;
            end
            if (last_proc) begin
               pend_in = 1'b0;
               state_in = ST_LIMIT;
            end else begin
               proc_in = cnt_ff[SLOT_W-1:0];
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_LIMIT: begin
            cnt_in = CNT_W'(1);
            pend_in = 1'b1;
            proc_in = '0;
            if (ring_active_ff && over_limit) begin
               ring_active_in = 1'b0;
               ring_start_in = '0;
               stopped_in = 1'b1;
               state_in = ST_STOP;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_STOP: begin
            // Mark every active slot done.
            rd_addr = cnt_ff[SLOT_W-1:0];
            wr_en = pend_ff;
            wr_data = stop_s;
            if (last_proc) begin
               pend_in = 1'b0;
               state_in = ST_DONE;
            end else begin
               proc_in = cnt_ff[SLOT_W-1:0];
               cnt_in = cnt_ff + CNT_W'(1);
            end
         end
         ST_DONE: begin
            rsp_valid_in = 1'b1;
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= slot_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         rd_ok_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         rd_ok_ff <= valid_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff <= '0;
         pend_ff <= 1'b0;
         max_ring_ff <= MAX_RING_RESET;
         ring_active_ff <= 1'b0;
         ring_start_ff <= '0;
         ring_slot_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         pend_ff <= pend_in;
         if (csr_we) begin
            max_ring_ff <= csr_wdata;
         end
         ring_active_ff <= ring_active_in;
         ring_start_ff <= ring_start_in;
         ring_slot_ff <= ring_slot_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      proc_ff <= proc_in;
      started_ff <= started_in;
      stopped_ff <= stopped_in;
      save_ff <= save_in;
      melody_ff <= melody_in;
      if (accept) begin
         hour_ff <= req_hour;
         minute_ff <= req_minute;
         weekday_ff <= req_weekday;
         now_ff <= req_now_seconds;
      end
      if (rsp_valid_in) begin
         rsp_started_ff <= started_ff;
         rsp_stopped_ff <= stopped_ff;
         rsp_save_ff <= save_ff;
         rsp_melody_ff <= melody_ff;
         rsp_slot_ff <= ring_slot_ff;
         rsp_ringing_ff <= ring_active_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_ring_started = rsp_started_ff;
   assign rsp_ring_slot = rsp_slot_ff;
   assign rsp_ring_melody = rsp_melody_ff;
   assign rsp_ring_stopped = rsp_stopped_ff;
   assign rsp_ringing = rsp_ringing_ff;
   assign rsp_save_needed = rsp_save_ff;

endmodule

@@ rtl/core/alm_checker.sv @@
// Port-level assertions for the alarm table matcher, bound to the top level.
module alm_checker (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_valid,
   input logic        rsp_ring_started,
   input logic [7:0]  rsp_ring_melody,
   input logic        rsp_ring_stopped,
   input logic        rsp_ringing
);

   // A result beat shows only once the block is free again.
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy) else $error("result beat while busy");

   // No result beat right after an accept.
   a_no_instant: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> !rsp_valid) else $error("result beat one cycle after accept");

   // One beat per item, never two in a row.
   a_single_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("back-to-back result beats");

   a_start_rings: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ring_started) |-> (rsp_ringing && !rsp_ring_stopped))
      else $error("start without ringing");

   a_melody_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ring_started) |-> (rsp_ring_melody == 8'd0))
      else $error("melody without start");

endmodule

bind alarm_table_matcher alm_checker u_alm_checker (
   .clock(clock),
   .reset(reset),
   .start(start),
   .busy(busy),
   .rsp_valid(rsp_valid),
   .rsp_ring_started(rsp_ring_started),
   .rsp_ring_melody(rsp_ring_melody),
   .rsp_ring_stopped(rsp_ring_stopped),
   .rsp_ringing(rsp_ringing)
);
